// ===== sv/jcrd_pkg.sv =====
// Shared constants, types and helper functions of the JPEG coefficient run decoder.
`default_nettype none
package jcrd_pkg;

    localparam int MAX_COMPONENTS = 3;
    localparam int NUM_QTABLES    = 4;
    localparam int BLOCK_COEFFS   = 64;

    localparam int POS_W   = $clog2(BLOCK_COEFFS);
    localparam int QSEL_W  = $clog2(NUM_QTABLES);
    localparam int QADDR_W = QSEL_W + POS_W;
    localparam int QDEPTH  = NUM_QTABLES * BLOCK_COEFFS;
    localparam int QVAL_W  = 8;
    localparam int COEF_W  = 16;
    localparam int EXTRA_W = 15;
    localparam int CNT_W   = POS_W + 1;

    localparam logic [7:0] SYM_EOB = 8'h00;
    localparam logic [7:0] SYM_ZRL = 8'hF0;
    localparam logic [3:0] MAX_CAT = 4'd15;
    localparam logic [CNT_W-1:0] ZRL_ZEROS = CNT_W'(16);
    localparam logic [CNT_W-1:0] BLOCK_LEN = CNT_W'(BLOCK_COEFFS);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BLOCK_COEFFS - 1);

    typedef enum logic [1:0] {
        CMD_SYMBOL = 2'd0,
        CMD_QWRITE = 2'd1,
        CMD_SCAN   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_NUM_COMP = 2'd0,
        REG_COMP0_QT = 2'd1,
        REG_COMP1_QT = 2'd2,
        REG_COMP2_QT = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_EMIT   = 5'b00100,
        S_MUL    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    localparam logic [POS_W-1:0] ZZ_TO_NAT [BLOCK_COEFFS] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    // Sign extension of JPEG magnitude bits: a clear top bit marks a negative value.
    function automatic logic [COEF_W-1:0] extend_bits(input logic [3:0] size,
                                                      input logic [EXTRA_W-1:0] bits);
        logic [COEF_W-1:0] mask;
        logic [COEF_W-1:0] v;
        logic [COEF_W-1:0] top;
        mask = (COEF_W'(1) << size) - COEF_W'(1);
        v    = {1'b0, bits} & mask;
        top  = mask ^ (mask >> 1);
        if (size == 4'd0) begin
            extend_bits = '0;
        end else if ((v & top) == '0) begin
            extend_bits = v - mask;
        end else begin
            extend_bits = v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/jcrd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jcrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/jpeg_coefficient_run_decoder.sv =====
// Top level of the JPEG baseline coefficient run decoder with its symbol sequencer.
//
//  Channel  Direction  Handshake             Payload
//  s_       in         s_valid / s_ready     command, symbol, extra bits, table write
//  m_       out        m_valid / m_ready     coefficient, position, component, flags
//  apb      in         psel/penable/pready   four 2-bit registers at 0x0, 0x4, 0x8, 0xC
//
// An item is taken only when the block is idle. A table write, new scan or ignored
// item is handled in S_IDLE; a coefficient symbol passes S_DECODE, then S_EMIT and
// S_OUT per zero and S_EMIT, S_MUL, S_OUT for the nonzero value, which passes the single
// table read port and the shared multiplier. A stalled result holds the sequencer in place.
// Reset is synchronous and active low; the quantization tables are not cleared.
`default_nettype none
module jpeg_coefficient_run_decoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_command,
    input  wire logic [7:0]                     s_symbol,
    input  wire logic [jcrd_pkg::EXTRA_W-1:0]   s_extra_bits,
    input  wire logic [jcrd_pkg::QSEL_W-1:0]    s_qt_select,
    input  wire logic [jcrd_pkg::POS_W-1:0]     s_qt_position,
    input  wire logic [jcrd_pkg::QVAL_W-1:0]    s_qt_value,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [jcrd_pkg::COEF_W-1:0]  m_coefficient,
    output logic [jcrd_pkg::POS_W-1:0]          m_natural_position,
    output logic [1:0]                          m_component,
    output logic                                m_block_end,
    output logic                                m_status,
    output logic                                m_last_of_run,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [3:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import jcrd_pkg::*;

    state_t state_reg, state_next;

    logic [1:0] num_comp_reg;
    logic [1:0] comp0_qt_reg;
    logic [1:0] comp1_qt_reg;
    logic [1:0] comp2_qt_reg;

    logic [COEF_W-1:0] pred_reg [MAX_COMPONENTS];
    logic [COEF_W-1:0] pred_next [MAX_COMPONENTS];
    logic [POS_W-1:0]  k_reg, k_next;
    logic [1:0]        comp_reg, comp_next;
    logic              halted_reg, halted_next;

    logic [7:0]         sym_reg, sym_next;
    logic [EXTRA_W-1:0] extra_reg, extra_next;
    logic [CNT_W-1:0]   zeros_reg, zeros_next;
    logic               has_val_reg, has_val_next;
    logic [COEF_W-1:0]  val_reg, val_next;

    logic [COEF_W-1:0] out_coef_reg, out_coef_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [1:0]        out_comp_reg, out_comp_next;
    logic              out_end_reg, out_end_next;
    logic              out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire;
    logic              out_fire;
    logic              cfg_write;
    logic              ram_we;
    logic [QADDR_W-1:0] ram_waddr;
    logic [QADDR_W-1:0] ram_raddr;
    logic [QVAL_W-1:0] ram_rdata;
    logic [1:0]        cur_qt;
    logic [1:0]        active_comp;
    logic [3:0]        dc_cat;
    logic [3:0]        run_len;
    logic [3:0]        ac_size;
    logic [CNT_W-1:0]  left_cnt;
    logic [CNT_W-1:0]  run_end;
    logic [COEF_W-1:0] dc_sum;
    logic signed [COEF_W+QVAL_W:0] product;

    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_comp_reg <= 2'd3;
            comp0_qt_reg <= 2'd0;
            comp1_qt_reg <= 2'd1;
            comp2_qt_reg <= 2'd1;
        end else if (cfg_write) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_NUM_COMP: num_comp_reg <= pwdata[1:0];
                REG_COMP0_QT: comp0_qt_reg <= pwdata[1:0];
                REG_COMP1_QT: comp1_qt_reg <= pwdata[1:0];
                REG_COMP2_QT: comp2_qt_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_NUM_COMP: prdata = {30'd0, num_comp_reg};
            REG_COMP0_QT: prdata = {30'd0, comp0_qt_reg};
            REG_COMP1_QT: prdata = {30'd0, comp1_qt_reg};
            REG_COMP2_QT: prdata = {30'd0, comp2_qt_reg};
            default:      prdata = '0;
        endcase
    end

    assign cur_qt = (comp_reg == 2'd0) ? comp0_qt_reg :
                    (comp_reg == 2'd1) ? comp1_qt_reg : comp2_qt_reg;
    assign active_comp = (num_comp_reg == 2'd0) ? 2'd1 : num_comp_reg;

    assign ram_we    = in_fire && (cmd_t'(s_command) == CMD_QWRITE);
    assign ram_waddr = {s_qt_select, s_qt_position};
    assign ram_raddr = {cur_qt, k_reg};

    jcrd_ram #(
        .WIDTH (QVAL_W),
        .DEPTH (QDEPTH)
    ) u_qtable (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_qt_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dc_cat   = (sym_reg > 8'(MAX_CAT)) ? MAX_CAT : sym_reg[3:0];
    assign run_len  = sym_reg[7:4];
    assign ac_size  = sym_reg[3:0];
    assign left_cnt = BLOCK_LEN - {1'b0, k_reg};
    assign run_end  = {1'b0, k_reg} + CNT_W'(run_len);
    assign dc_sum   = pred_reg[comp_reg] + extend_bits(dc_cat, extra_reg);
    assign product  = $signed(val_reg) * $signed({1'b0, ram_rdata});

    always_comb begin
        state_next      = state_reg;
        pred_next       = pred_reg;
        k_next          = k_reg;
        comp_next       = comp_reg;
        halted_next     = halted_reg;
        sym_next        = sym_reg;
        extra_next      = extra_reg;
        zeros_next      = zeros_reg;
        has_val_next    = has_val_reg;
        val_next        = val_reg;
        out_coef_next   = out_coef_reg;
        out_pos_next    = out_pos_reg;
        out_comp_next   = out_comp_reg;
        out_end_next    = out_end_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (cmd_t'(s_command))
                        CMD_SCAN: begin
                            for (int i = 0; i < MAX_COMPONENTS; i++) begin
                                pred_next[i] = '0;
                            end
                            k_next      = '0;
                            comp_next   = '0;
                            halted_next = 1'b0;
                        end
                        CMD_SYMBOL: begin
                            if (!halted_reg) begin
                                sym_next   = s_symbol;
                                extra_next = s_extra_bits;
                                state_next = S_DECODE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DECODE: begin
                zeros_next   = '0;
                has_val_next = 1'b0;
                state_next   = S_EMIT;
                if (k_reg == '0) begin
                    pred_next[comp_reg] = dc_sum;
                    val_next            = dc_sum;
                    has_val_next        = 1'b1;
                end else if (sym_reg == SYM_EOB) begin
                    zeros_next = left_cnt;
                end else if (sym_reg == SYM_ZRL) begin
                    zeros_next = (left_cnt < ZRL_ZEROS) ? left_cnt : ZRL_ZEROS;
                end else if (run_end >= BLOCK_LEN || ac_size == 4'd0) begin
                    out_coef_next   = '0;
                    out_pos_next    = '0;
                    out_comp_next   = comp_reg;
                    out_end_next    = 1'b0;
                    out_status_next = 1'b1;
                    out_last_next   = 1'b1;
                    halted_next     = 1'b1;
                    state_next      = S_OUT;
                end else begin
                    zeros_next   = CNT_W'(run_len);
                    val_next     = extend_bits(ac_size, extra_reg);
                    has_val_next = 1'b1;
                end
            end
            S_EMIT: begin
                if (zeros_reg != '0) begin
                    out_coef_next   = '0;
                    out_pos_next    = ZZ_TO_NAT[k_reg];
                    out_comp_next   = comp_reg;
                    out_end_next    = (k_reg == LAST_POS);
                    out_status_next = 1'b0;
                    out_last_next   = (zeros_reg == CNT_W'(1)) && !has_val_reg;
                    state_next      = S_OUT;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                out_coef_next   = product[COEF_W-1:0];
                out_pos_next    = ZZ_TO_NAT[k_reg];
                out_comp_next   = comp_reg;
                out_end_next    = (k_reg == LAST_POS);
                out_status_next = 1'b0;
                out_last_next   = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (out_fire) begin
                    if (out_status_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next = k_reg + POS_W'(1);
                        if (k_reg == LAST_POS) begin
                            comp_next = ({1'b0, comp_reg} + 3'd1 >= {1'b0, active_comp}) ?
                                        2'd0 : comp_reg + 2'd1;
                        end
                        if (zeros_reg != '0) begin
                            zeros_next = zeros_reg - CNT_W'(1);
                        end else begin
                            has_val_next = 1'b0;
                        end
                        state_next = out_last_reg ? S_IDLE : S_EMIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            comp_reg   <= '0;
            halted_reg <= 1'b0;
            for (int i = 0; i < MAX_COMPONENTS; i++) begin
                pred_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            comp_reg   <= comp_next;
            halted_reg <= halted_next;
            pred_reg   <= pred_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg        <= sym_next;
        extra_reg      <= extra_next;
        zeros_reg      <= zeros_next;
        has_val_reg    <= has_val_next;
        val_reg        <= val_next;
        out_coef_reg   <= out_coef_next;
        out_pos_reg    <= out_pos_next;
        out_comp_reg   <= out_comp_next;
        out_end_reg    <= out_end_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_coefficient      = $signed(out_coef_reg);
    assign m_natural_position = out_pos_reg;
    assign m_component        = out_comp_reg;
    assign m_block_end        = out_end_reg;
    assign m_status           = out_status_reg;
    assign m_last_of_run      = out_last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("An item was taken while a result was pending.");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last_of_run && m_coefficient == '0 && !m_block_end)
        else $error("An error result carries unexpected fields.");

    a_block_end_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_end |-> m_natural_position == ZZ_TO_NAT[LAST_POS])
        else $error("A block ended before its final position.");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && cmd_t'(s_command) == CMD_SYMBOL && halted_reg |=> state_reg == S_IDLE)
        else $error("A symbol was decoded while halted.");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && m_status |=> halted_reg && state_reg == S_IDLE)
        else $error("An error result did not leave the block halted.");

endmodule
`default_nettype wire
